// ===== hw/rtl/cds_pkg.sv =====
// Shared constants, register indexes and status codes of the chunk directory scanner.
package cds_pkg;

    localparam int TABLE_ENTRIES_DEF = 5;
    localparam int OFFSET_BITS_DEF   = 32;
    localparam int MAX_ENTRIES       = 5;
    localparam int HEADER_LEN        = 8;
    localparam int BYTE_W            = 8;
    localparam int ID_W              = 32;
    localparam int SIZE_W            = 32;
    localparam int HDR_W             = (HEADER_LEN - 1) * BYTE_W;
    localparam int HCNT_W            = $clog2(HEADER_LEN);
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int INDEX_W           = 3;
    localparam int OFS_PORT_W        = 32;
    localparam int STATUS_W          = 3;

    localparam logic [ID_W-1:0] ID_RESET [MAX_ENTRIES] = '{
        32'h424B4844, 32'h44494458, 32'h44415441, 32'h48495243, 32'h53544944
    };

    localparam logic [CFG_IDX_W-1:0] REG_ID_0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_1       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ID_2       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ID_4       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPTIONAL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_REPEATABLE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IGNORE     = 3'd7;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_TRUNC    = 3'd1,
        ST_OVERRUN  = 3'd2,
        ST_DUP      = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_MISSING  = 3'd5
    } status_t;

endpackage

// ===== hw/rtl/cds_result_bank.sv =====
// Result bank: holds one stream's per-entry results and hands them out one item a cycle while result_ready is high.
module cds_result_bank
    import cds_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  logic [TABLE_ENTRIES-1:0] load_found,
    input  logic [OFFSET_BITS-1:0]   load_offsets [TABLE_ENTRIES],
    input  logic [SIZE_W-1:0]        load_sizes [TABLE_ENTRIES],
    input  status_t                  load_status,
    output logic                     can_load,
    output logic                     result_valid,
    input  logic                     result_ready,
    output logic [INDEX_W-1:0]       entry_index,
    output logic                     entry_found,
    output logic [OFS_PORT_W-1:0]    payload_offset,
    output logic [SIZE_W-1:0]        payload_size,
    output logic [STATUS_W-1:0]      status,
    output logic                     last_of_run
);

    localparam int ENTRY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic                     valid_reg;
    logic [ENTRY_W-1:0]       idx_reg;
    logic [TABLE_ENTRIES-1:0] found_reg;
    logic [OFFSET_BITS-1:0]   offs_reg [TABLE_ENTRIES];
    logic [SIZE_W-1:0]        sizes_reg [TABLE_ENTRIES];
    status_t                  status_reg;
    logic                     is_last;

    assign is_last  = (idx_reg == ENTRY_W'(TABLE_ENTRIES - 1));
    assign can_load = !valid_reg || (result_ready && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (valid_reg && result_ready)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + ENTRY_W'(1);
            end
        end
    end

    // Absent entries are stored as zero so that the output side is a plain select.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg  <= load_found;
            status_reg <= load_status;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                offs_reg[i]  <= load_found[i] ? load_offsets[i] : '0;
                sizes_reg[i] <= load_found[i] ? load_sizes[i] : '0;
            end
        end
    end

    assign result_valid   = valid_reg;
    assign entry_index    = INDEX_W'(idx_reg);
    assign entry_found    = found_reg[idx_reg];
    assign payload_offset = OFS_PORT_W'(offs_reg[idx_reg]);
    assign payload_size   = sizes_reg[idx_reg];
    assign status         = status_reg;
    assign last_of_run    = is_last;

endmodule

// ===== hw/rtl/chunk_directory_scanner_unit.sv =====
// Top level of the chunk directory scanner: byte parser, id table and configuration registers.
// Throughput: one byte item per cycle while byte_ready is high; each byte is parsed as it is taken.
// Results: the result item for entry 0 is shown in the cycle after the final byte is taken,
// the other entries follow one per cycle while result_ready is high.
// A final byte is held off only while the result bank still holds an earlier stream's results.
// Reset: ids return to their default table, masks and ignore flag clear, the parser is empty.
module chunk_directory_scanner_unit
    import cds_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  logic [BYTE_W-1:0]      data_byte,
    input  logic                   end_of_stream,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [INDEX_W-1:0]     entry_index,
    output logic                   entry_found,
    output logic [OFS_PORT_W-1:0]  payload_offset,
    output logic [SIZE_W-1:0]      payload_size,
    output logic [STATUS_W-1:0]    status,
    output logic                   last_of_run
);

    // Configuration registers.
    logic [ID_W-1:0]          ids_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] opt_reg;
    logic [TABLE_ENTRIES-1:0] rep_reg;
    logic                     ign_reg;

    // Parser state for the stream in progress.
    logic [OFFSET_BITS-1:0]   pos_reg,    pos_next;
    logic [HDR_W-1:0]         hdr_reg,    hdr_next;
    logic [HCNT_W-1:0]        hcnt_reg,   hcnt_next;
    logic [SIZE_W-1:0]        remain_reg, remain_next;
    logic [TABLE_ENTRIES-1:0] found_reg,  found_next;
    status_t                  err_reg,    err_next;
    logic [OFFSET_BITS-1:0]   offs_reg  [TABLE_ENTRIES];
    logic [OFFSET_BITS-1:0]   offs_next [TABLE_ENTRIES];
    logic [SIZE_W-1:0]        sizes_reg  [TABLE_ENTRIES];
    logic [SIZE_W-1:0]        sizes_next [TABLE_ENTRIES];

    // State as it stands once the current byte has been parsed, before the end of a stream
    // clears it.
    logic [HCNT_W-1:0]        step_hcnt;
    logic [SIZE_W-1:0]        step_remain;
    logic [TABLE_ENTRIES-1:0] step_found;
    status_t                  step_err;
    status_t                  final_status;

    logic [TABLE_ENTRIES-1:0] match;
    logic [ID_W-1:0]          hdr_id;
    logic [SIZE_W-1:0]        hdr_size;
    logic [OFFSET_BITS-1:0]   pay_ofs;
    logic                     byte_fire;
    logic                     bank_can_load;

    assign byte_ready = !end_of_stream || bank_can_load;
    assign byte_fire  = byte_valid && byte_ready;

    // ------------------------------------------------------------------
    // Configuration port. Indexes for ids beyond the table are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                ids_reg[i] <= ID_RESET[i];
            end
            opt_reg <= '0;
            rep_reg <= '0;
            ign_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index) inside
                REG_ID_0, REG_ID_1, REG_ID_2, REG_ID_3, REG_ID_4:
                begin
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (cfg_index == CFG_IDX_W'(i))
                        begin
                            ids_reg[i] <= cfg_data[ID_W-1:0];
                        end
                    end
                end
                REG_OPTIONAL:   opt_reg <= cfg_data[TABLE_ENTRIES-1:0];
                REG_REPEATABLE: rep_reg <= cfg_data[TABLE_ENTRIES-1:0];
                REG_IGNORE:     ign_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Header decode. The first seven header bytes sit in hdr_reg; the
    // eighth is the byte now on the input, so a header finishes in the
    // cycle its last byte is taken. Every table entry is compared at once.
    // ------------------------------------------------------------------
    assign hdr_id   = hdr_reg[HDR_W-1 -: ID_W];
    assign hdr_size = {hdr_reg[SIZE_W-BYTE_W-1:0], data_byte};
    assign pay_ofs  = pos_reg + OFFSET_BITS'(1);

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match[i] = (ids_reg[i] == hdr_id);
        end
    end

    // ------------------------------------------------------------------
    // Parser step. Once an error is latched the bytes of the stream are
    // dropped; only the byte count and the end of stream still matter.
    // ------------------------------------------------------------------
    always_comb
    begin
        hdr_next    = hdr_reg;
        step_hcnt   = hcnt_reg;
        step_remain = remain_reg;
        step_found  = found_reg;
        step_err    = err_reg;
        offs_next   = offs_reg;
        sizes_next  = sizes_reg;

        if (err_reg == ST_OK)
        begin
            if (remain_reg != '0)
            begin
                step_remain = remain_reg - SIZE_W'(1);
            end
            else if (hcnt_reg == HCNT_W'(HEADER_LEN - 1))
            begin
                hdr_next  = '0;
                step_hcnt = '0;
                // A payload that would start after the final byte is an overrun, and
                // that verdict comes before any check of the id.
                if (end_of_stream && (hdr_size != '0))
                begin
                    step_err = ST_OVERRUN;
                end
                else if ((match == '0) && !ign_reg)
                begin
                    step_err = ST_UNKNOWN;
                end
                else if ((match & found_reg & ~rep_reg) != '0)
                begin
                    step_err = ST_DUP;
                end
                else
                begin
                    // Several entries may share one id: each of them not yet seen records it.
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                    begin
                        if (match[i] && !found_reg[i])
                        begin
                            offs_next[i]  = pay_ofs;
                            sizes_next[i] = hdr_size;
                        end
                    end
                    step_found  = found_reg | match;
                    step_remain = hdr_size;
                end
            end
            else
            begin
                hdr_next  = {hdr_reg[HDR_W-BYTE_W-1:0], data_byte};
                step_hcnt = hcnt_reg + HCNT_W'(1);
            end
        end
    end

    // End of stream verdict: a partial header, then an unfinished payload, then a required
    // entry that never showed up. An error already latched wins over all of these.
    always_comb
    begin
        final_status = step_err;
        if (step_err == ST_OK)
        begin
            if (step_hcnt != '0)
            begin
                final_status = ST_TRUNC;
            end
            else if (step_remain != '0)
            begin
                final_status = ST_OVERRUN;
            end
            else if ((~step_found & ~opt_reg) != '0)
            begin
                final_status = ST_MISSING;
            end
        end
    end

    // On the final byte the stream state starts afresh for the next file.
    always_comb
    begin
        if (end_of_stream)
        begin
            pos_next    = '0;
            hcnt_next   = '0;
            remain_next = '0;
            found_next  = '0;
            err_next    = ST_OK;
        end
        else
        begin
            pos_next    = pos_reg + OFFSET_BITS'(1);
            hcnt_next   = step_hcnt;
            remain_next = step_remain;
            found_next  = step_found;
            err_next    = step_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hdr_reg    <= '0;
            hcnt_reg   <= '0;
            remain_reg <= '0;
            found_reg  <= '0;
            err_reg    <= ST_OK;
        end
        else if (byte_fire)
        begin
            pos_reg    <= pos_next;
            hdr_reg    <= end_of_stream ? '0 : hdr_next;
            hcnt_reg   <= hcnt_next;
            remain_reg <= remain_next;
            found_reg  <= found_next;
            err_reg    <= err_next;
        end
    end

    // Entry offsets and sizes are only read where the found bit is set, and a found bit is
    // only set together with its entry, so these need no reset.
    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            offs_reg  <= offs_next;
            sizes_reg <= sizes_next;
        end
    end

    // ------------------------------------------------------------------
    // Result bank: the snapshot taken on the final byte is drained while
    // the parser already takes bytes of the next stream.
    // ------------------------------------------------------------------
    cds_result_bank #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_result_bank (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (byte_fire && end_of_stream),
        .load_found     (step_found),
        .load_offsets   (offs_next),
        .load_sizes     (sizes_next),
        .load_status    (final_status),
        .can_load       (bank_can_load),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .entry_index    (entry_index),
        .entry_found    (entry_found),
        .payload_offset (payload_offset),
        .payload_size   (payload_size),
        .status         (status),
        .last_of_run    (last_of_run)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A final byte is only taken when the bank is empty or gives up its last item now.
    a_no_bank_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && end_of_stream) |-> (!result_valid || (result_ready && last_of_run)))
        else $error("final byte taken while earlier results were still pending");

    // The results of a stream start with entry 0 in the very next cycle.
    a_results_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && end_of_stream) |=> (result_valid && (entry_index == '0)))
        else $error("results did not start with entry 0 after the final byte");

    // A latched error holds until the end of its stream.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((err_reg != ST_OK) && !(byte_fire && end_of_stream)) |=> (err_reg == $past(err_reg)))
        else $error("latched error changed inside a stream");

    // Found entries never disappear while a stream is in progress.
    a_found_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_fire && !end_of_stream) |=> ((found_reg & $past(found_reg)) == $past(found_reg)))
        else $error("found bit cleared inside a stream");

endmodule

// ===== tb/sv/tb_chunk_directory_scanner_unit.sv =====
// Self-checking testbench of the chunk directory scanner with its own model of the parser.
module tb_chunk_directory_scanner_unit;
    import cds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The watchdog gives up after this many cycles in which nothing is accepted.
    // The slowest correct run never comes near it: sender and receiver gaps are short.
    localparam int STALL_LIMIT   = 2000;
    localparam int IDLE_PERCENT  = 27;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 20;
    localparam int PHASES        = 4;

    // One result item of the scanner: the verdict on one table entry.
    typedef struct packed {
        logic [INDEX_W-1:0]    idx;
        logic                  found;
        logic [OFS_PORT_W-1:0] offset;
        logic [SIZE_W-1:0]     size;
        status_t               stat;
        logic                  last;
    } dir_entry_t;

    // One row of the directed part. Where typed is set, the status of the
    // stream that ends on this byte is written in by hand.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              typed;
        status_t           stat;
    } directed_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  byte_valid = 1'b0;
    logic                  byte_ready;
    logic [BYTE_W-1:0]     data_byte = '0;
    logic                  end_of_stream = 1'b0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [INDEX_W-1:0]    entry_index;
    logic                  entry_found;
    logic [OFS_PORT_W-1:0] payload_offset;
    logic [SIZE_W-1:0]     payload_size;
    logic [STATUS_W-1:0]   status;
    logic                  last_of_run;

    // Results that the model of the scanner has predicted and the block has not yet shown.
    dir_entry_t      expected_entries [$];
    logic [BYTE_W-1:0] file_bytes [$];

    int  fail_count   = 0;
    int  stall_cycles = 0;
    bit  gaps_on      = 1'b1;

    // The model's copy of the configuration registers.
    logic [ID_W-1:0]          cfg_ids [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]   optional_bits;
    logic [MAX_ENTRIES-1:0]   repeatable_bits;
    logic                     skip_unknown;

    // The model's copy of the parser state.
    logic [31:0]              byte_pos;
    logic [HDR_W-1:0]         header_shift;
    logic [3:0]               header_fill;
    logic [31:0]              payload_left;
    logic [MAX_ENTRIES-1:0]   found_bits;
    logic [OFS_PORT_W-1:0]    first_offsets [MAX_ENTRIES];
    logic [SIZE_W-1:0]        first_sizes [MAX_ENTRIES];
    status_t                  latched_status;

    // Three short streams under the reset configuration: a lone byte that leaves a
    // partial header, a chunk seen twice that is not repeatable, and a header with a
    // nonzero size that completes on the final byte, so overrun wins over unknown.
    directed_row_t directed_rows [26] = '{
        '{8'hFF, 1'b1, 1'b1, ST_TRUNC},
        '{8'h44, 1'b0, 1'b0, ST_OK}, '{8'h41, 1'b0, 1'b0, ST_OK},
        '{8'h54, 1'b0, 1'b0, ST_OK}, '{8'h41, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b0, 1'b0, ST_OK},
        '{8'h80, 1'b0, 1'b0, ST_OK},
        '{8'h44, 1'b0, 1'b0, ST_OK}, '{8'h41, 1'b0, 1'b0, ST_OK},
        '{8'h54, 1'b0, 1'b0, ST_OK}, '{8'h41, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b1, 1'b1, ST_DUP},
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, ST_OK}, '{8'hFF, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h00, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, ST_OK}, '{8'h01, 1'b1, 1'b1, ST_OVERRUN}
    };

    chunk_directory_scanner_unit DUT (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Clears the per-stream state, as the block does at reset and after each final byte.
    task automatic clear_scan();
        byte_pos       = '0;
        header_shift   = '0;
        header_fill    = '0;
        payload_left   = '0;
        found_bits     = '0;
        latched_status = ST_OK;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            first_offsets[i] = '0;
            first_sizes[i]   = '0;
        end
    endtask

    // Advances the model by one accepted byte item. On the final byte of a stream
    // it queues one expected result per table entry and starts afresh.
    task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic eos);
        logic [ID_W-1:0]        hdr_id;
        logic [SIZE_W-1:0]      hdr_size;
        logic [31:0]            pay_ofs;
        logic [MAX_ENTRIES-1:0] match;
        dir_entry_t             ent;
        if (latched_status == ST_OK)
        begin
            if (payload_left != 0)
            begin
                payload_left = payload_left - 1;
            end
            else if (header_fill >= HEADER_LEN - 1)
            begin
                hdr_id       = header_shift[HDR_W-1:24];
                hdr_size     = {header_shift[23:0], b};
                header_shift = '0;
                header_fill  = '0;
                pay_ofs      = byte_pos + 1;
                for (int i = 0; i < MAX_ENTRIES; i++)
                    match[i] = (cfg_ids[i] == hdr_id);
                // A payload cannot follow a header that ends the stream.
                if (eos && hdr_size != 0)
                    latched_status = ST_OVERRUN;
                else if (match == '0 && !skip_unknown)
                    latched_status = ST_UNKNOWN;
                else if ((match & found_bits & ~repeatable_bits) != '0)
                    latched_status = ST_DUP;
                else
                begin
                    // Every matching entry not yet found records this chunk.
                    for (int i = 0; i < MAX_ENTRIES; i++)
                    begin
                        if (match[i] && !found_bits[i])
                        begin
                            first_offsets[i] = pay_ofs;
                            first_sizes[i]   = hdr_size;
                        end
                    end
                    found_bits   = found_bits | match;
                    payload_left = hdr_size;
                end
            end
            else
            begin
                header_shift = {header_shift[HDR_W-9:0], b};
                header_fill  = header_fill + 4'd1;
            end
        end
        if (!eos)
        begin
            byte_pos = byte_pos + 1;
        end
        else
        begin
            if (latched_status == ST_OK)
            begin
                if (header_fill != 0)
                    latched_status = ST_TRUNC;
                else if (payload_left != 0)
                    latched_status = ST_OVERRUN;
                else if ((~found_bits & ~optional_bits) != '0)
                    latched_status = ST_MISSING;
            end
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                ent.idx    = INDEX_W'(i);
                ent.found  = found_bits[i];
                ent.offset = found_bits[i] ? first_offsets[i] : '0;
                ent.size   = found_bits[i] ? first_sizes[i] : '0;
                ent.stat   = latched_status;
                ent.last   = (i == MAX_ENTRIES - 1);
                expected_entries.push_back(ent);
            end
            clear_scan();
        end
    endtask

    // Offers one byte item, with random idle cycles before it, and waits until it is
    // taken. Called at a falling edge and returns at the falling edge after acceptance,
    // with valid still high so that a following item can go out without a gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
        while (gaps_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid    <= 1'b1;
        data_byte     <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        scan_byte(b, eos);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // Rewrites every register once the scanner has shown all predicted results and a
    // settling wait has passed. The upper bits of the mask words are not all zero,
    // since the block must drop them.
    task automatic write_config(input logic [MAX_ENTRIES-1:0][ID_W-1:0] new_ids,
                                input logic [CFG_DATA_W-1:0] opt_word,
                                input logic [CFG_DATA_W-1:0] rep_word,
                                input logic [CFG_DATA_W-1:0] ign_word);
        byte_valid <= 1'b0;
        while (expected_entries.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            put_reg(REG_ID_0 + CFG_IDX_W'(i), new_ids[i]);
            cfg_ids[i] = new_ids[i];
        end
        put_reg(REG_OPTIONAL, opt_word);
        put_reg(REG_REPEATABLE, rep_word);
        put_reg(REG_IGNORE, ign_word);
        cfg_write       <= 1'b0;
        optional_bits   = opt_word[MAX_ENTRIES-1:0];
        repeatable_bits = rep_word[MAX_ENTRIES-1:0];
        skip_unknown    = ign_word[0];
    endtask

    // Builds one random file in file_bytes. Most chunks carry an id from the table and
    // a short payload; some carry an unknown id or a huge size, and some files end in
    // a partial header or a partial payload.
    task automatic build_stream();
        int              chunks;
        int              sel;
        int              ending;
        int              pay_count;
        bit              stop;
        logic [ID_W-1:0] cid;
        logic [SIZE_W-1:0] csize;
        file_bytes.delete();
        chunks = $urandom_range(0, 4);
        stop   = 1'b0;
        for (int c = 0; c < chunks && !stop; c++)
        begin
            cid   = ($urandom_range(3) != 0) ? cfg_ids[$urandom_range(MAX_ENTRIES - 1)]
                                             : $urandom;
            sel   = $urandom_range(9);
            csize = (sel == 0) ? $urandom : ((sel == 1) ? 0 : $urandom_range(1, 5));
            for (int k = 3; k >= 0; k--)
                file_bytes.push_back(cid[8*k +: 8]);
            for (int k = 3; k >= 0; k--)
                file_bytes.push_back(csize[8*k +: 8]);
            // A huge size cannot be filled, so the file stops inside its payload.
            stop      = (sel == 0);
            pay_count = stop ? $urandom_range(0, 3) : int'(csize);
            repeat (pay_count) file_bytes.push_back(BYTE_W'($urandom_range(255)));
        end
        ending = $urandom_range(9);
        if (!stop && ending == 0)
        begin
            repeat ($urandom_range(1, 7)) file_bytes.push_back(BYTE_W'($urandom_range(255)));
        end
        else if (!stop && ending == 1)
        begin
            cid   = cfg_ids[$urandom_range(MAX_ENTRIES - 1)];
            csize = $urandom_range(1, 9);
            for (int k = 3; k >= 0; k--)
                file_bytes.push_back(cid[8*k +: 8]);
            for (int k = 3; k >= 0; k--)
                file_bytes.push_back(csize[8*k +: 8]);
            repeat ($urandom_range(0, int'(csize) - 1))
                file_bytes.push_back(BYTE_W'($urandom_range(255)));
        end
        if (file_bytes.size() == 0)
            file_bytes.push_back(BYTE_W'($urandom_range(255)));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // The receiver stalls at random, except while the gaps are switched off.
    always @(negedge clk)
        result_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PERCENT);

    // Every accepted result item is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        dir_entry_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_entries.size() == 0)
            begin
                $error("result item for entry %0d with no expectation waiting", entry_index);
                fail_count++;
            end
            else
            begin
                want = expected_entries.pop_front();
                check_field("entry_index", 32'(want.idx), 32'(entry_index));
                check_field("entry_found", 32'(want.found), 32'(entry_found));
                check_field("payload_offset", want.offset, payload_offset);
                check_field("payload_size", want.size, payload_size);
                check_field("status", 32'(want.stat), 32'(status));
                check_field("last_of_run", 32'(want.last), 32'(last_of_run));
            end
        end
    end

    // Counts cycles in which no item moves on either channel and no register is written.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (byte_valid && byte_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb_chunk_directory_scanner_unit: FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [MAX_ENTRIES-1:0][ID_W-1:0] phase_ids;
        int                               phase_bytes;
        for (int i = 0; i < MAX_ENTRIES; i++)
            cfg_ids[i] = ID_RESET[i];
        optional_bits   = '0;
        repeatable_bits = '0;
        skip_unknown    = 1'b0;
        clear_scan();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset configuration. Rows with a typed status
        // override the predicted one; all other fields come from the model.
        foreach (directed_rows[r])
        begin
            send_byte(directed_rows[r].value, directed_rows[r].last);
            if (directed_rows[r].typed)
            begin
                for (int k = 1; k <= MAX_ENTRIES; k++)
                    expected_entries[expected_entries.size() - k].stat = directed_rows[r].stat;
            end
        end

        // Random part, one configuration per phase. The third phase runs with no
        // idling on either side.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                phase_ids[i] = $urandom;
            case (phase)
                0:
                    write_config(phase_ids, 32'hFFFF_FFFF, CFG_DATA_W'({$urandom, 5'b0}),
                                 32'hFFFF_FFFF);
                1:
                begin
                    // Two entries share one id, and every entry may repeat.
                    phase_ids[3] = phase_ids[1];
                    write_config(phase_ids, $urandom, 32'h0000_001F,
                                 CFG_DATA_W'({$urandom, 1'b0}));
                end
                2:
                begin
                    phase_ids[0] = 32'h0000_0000;
                    phase_ids[1] = 32'hFFFF_FFFF;
                    write_config(phase_ids, 32'h0, $urandom, 32'h1);
                end
                default:
                begin
                    for (int i = 0; i < MAX_ENTRIES; i++)
                        phase_ids[i] = ID_RESET[i];
                    write_config(phase_ids, $urandom, $urandom, $urandom);
                end
            endcase
            gaps_on     = (phase != 2);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                build_stream();
                for (int k = 0; k < file_bytes.size(); k++)
                    send_byte(file_bytes[k], k == file_bytes.size() - 1);
                phase_bytes += file_bytes.size();
            end
        end

        // Drain: wait for every predicted result, then a little longer for strays.
        byte_valid <= 1'b0;
        while (expected_entries.size() != 0)
            @(negedge clk);
        repeat (4 * SETTLE_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("tb_chunk_directory_scanner_unit: PASS");
        else
            $display("tb_chunk_directory_scanner_unit: FAIL");
        $finish;
    end

endmodule
